### sv/ltag_pkg.sv
// Shared types and constants for the linear-to-tiled address generator.
// Depends on nothing; the interfaces and the top level import it.
package ltag_pkg;

    // Fixed field widths of the channels
    localparam int SRC_W      = 27;
    localparam int OUT_W      = 24;
    localparam int COUNT_W    = 20;
    localparam int STRIDE_W   = 16;
    localparam int DIM_W      = 7;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register map
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_STRIDE = 2'd2
    } cfg_reg_t;

    // Sub-tile slot within a tile and its placement: bit 0 right half, bit 1 bottom half
    typedef logic [1:0] subtile_t;
    typedef logic [1:0] place_t;

    localparam subtile_t SUB_LAST = 2'd3;

    localparam place_t PLACE_TL = 2'd0;
    localparam place_t PLACE_TR = 2'd1;
    localparam place_t PLACE_BL = 2'd2;
    localparam place_t PLACE_BR = 2'd3;

    // Map the sub-tile slot to its placement; odd tile rows take the diagonally opposite placement
    function automatic place_t place_lookup(input logic odd, input subtile_t slot);
        place_t p;
        p = PLACE_TL;
        case (slot)
            2'd0: p = odd ? PLACE_BR : PLACE_TL;
            2'd1: p = odd ? PLACE_TR : PLACE_BL;
            2'd2: p = odd ? PLACE_TL : PLACE_BR;
            2'd3: p = odd ? PLACE_BL : PLACE_TR;
            default: p = PLACE_TL;
        endcase
        return p;
    endfunction

endpackage

### sv/ltag_ifs.sv
// Valid/ready channel interfaces of the linear-to-tiled address generator.
// Depends on ltag_pkg for the field widths.

// Request channel: one transfer asks for the next chunk address
interface ltag_req_if import ltag_pkg::*; ();
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

// Response channel: one transfer carries one chunk address pair
interface ltag_rsp_if import ltag_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SRC_W-1:0] src_offset;
    logic [OUT_W-1:0] out_offset;
    logic             last_chunk;

    modport source (output valid, output src_offset, output out_offset,
                    output last_chunk, input ready);
    modport sink   (input valid, input src_offset, input out_offset,
                    input last_chunk, output ready);
endinterface

// Configuration write channel
interface ltag_cfg_if import ltag_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

### sv/linear_to_tiled_address_generator.sv
// Top level of the linear-to-tiled address generator: position counters,
// address pipeline and configuration registers. Depends on ltag_pkg and ltag_ifs.
//
// Each request transfer yields one response transfer with the linear source
// offset and the tiled destination offset of the next 16-byte chunk in
// T-format order; restart=1 goes back to the first chunk, and the chunk after
// the last one wraps to the first. One chunk per clock is sustained while
// rsp.ready stays high: the position counters advance once per transfer, and
// the address arithmetic runs in two registered stages (placement sums, then
// the row-times-stride multiply): a request passes the first-stage register,
// then the output register, before its response appears. The configuration
// port is always ready; write it only while no request is in flight.
module linear_to_tiled_address_generator import ltag_pkg::*; #(
    parameter int MICRO_ROW_BYTES   = 16,
    parameter int MICRO_ROWS        = 4,
    parameter int SUBTILE_ROWS      = 16,
    parameter int SUBTILE_ROW_BYTES = 64,
    parameter int MAX_TILES         = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    ltag_req_if.sink          req,
    ltag_rsp_if.source        rsp,
    ltag_cfg_if.sink          cfg
);

    localparam int MPR_RAW = SUBTILE_ROW_BYTES / MICRO_ROW_BYTES;
    localparam int MPR     = (MPR_RAW > 0) ? MPR_RAW : 1;
    localparam int MHN     = SUBTILE_ROWS / MICRO_ROWS;
    // A sub-tile is MHN * MPR chunks, walked micro row first, then micro column
    localparam int CPS     = MHN * MPR;
    localparam int T_LAST  = (CPS - 1) % MICRO_ROWS;
    localparam int MW_LAST = ((CPS - 1) / MICRO_ROWS) % MPR;
    localparam int MH_LAST = (CPS - 1) / (MICRO_ROWS * MPR);
    localparam int TWB     = 2 * SUBTILE_ROW_BYTES;
    localparam int TR      = 2 * SUBTILE_ROWS;
    localparam int CW      = $clog2(MAX_TILES + 1);
    localparam int CLW     = (CW > DIM_W) ? CW : DIM_W;
    localparam int TW      = $clog2(MICRO_ROWS);
    localparam int MWW     = (MPR > 1) ? $clog2(MPR) : 1;
    localparam int MHW     = (MH_LAST > 0) ? $clog2(MH_LAST + 1) : 1;
    localparam int RW      = $clog2(TR);

    // Configuration registers
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [STRIDE_W-1:0] stride_reg;

    // Position of the next chunk
    logic [CW-1:0]      tile_row_reg,  tile_row_next;
    logic [CW-1:0]      tile_step_reg, tile_step_next;
    subtile_t           sub_reg,       sub_next;
    logic [TW-1:0]      t_reg,         t_next;
    logic [MWW-1:0]     mw_reg,        mw_next;
    logic [MHW-1:0]     mh_reg,        mh_next;
    logic [SRC_W-1:0]   row_base_reg,  row_base_next;
    logic [COUNT_W-1:0] count_reg,     count_next;

    // First pipeline stage
    logic               s1_valid_reg, s1_valid_next;
    logic [SRC_W-1:0]   s1_lin_reg;
    logic [RW-1:0]      s1_rowoff_reg;
    logic [COUNT_W-1:0] s1_count_reg;
    logic               s1_last_reg;

    // Output stage
    logic               out_valid_reg, out_valid_next;
    logic [SRC_W-1:0]   out_src_reg;
    logic [OUT_W-1:0]   out_off_reg;
    logic               out_last_reg;

    // Handshake
    logic s2_adv, s1_adv, acc;

    // Current chunk after an optional clear
    logic [CW-1:0]      w, h;
    logic               clr;
    logic [CW-1:0]      cur_row, cur_step, col;
    subtile_t           cur_sub;
    logic [TW-1:0]      cur_t;
    logic [MWW-1:0]     cur_mw;
    logic [MHW-1:0]     cur_mh;
    logic [SRC_W-1:0]   cur_base;
    logic [COUNT_W-1:0] cur_count;
    logic               odd, cur_last, sub_end;
    place_t             place;
    logic [SRC_W-1:0]   lin;
    logic [RW-1:0]      rowoff;

    // Force a tile count into 1..MAX_TILES
    function automatic logic [CW-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [CLW-1:0] vx;
        vx = CLW'(v);
        if (v == '0)
            return CW'(1);
        else if (vx > CLW'(MAX_TILES))
            return CW'(MAX_TILES);
        else
            return CW'(vx);
    endfunction

    // Stall chain: the output register frees stage one, stage one frees the request side
    assign s2_adv    = !out_valid_reg || rsp.ready;
    assign s1_adv    = !s1_valid_reg || s2_adv;
    assign req.ready = s1_adv;
    assign acc       = req.valid && s1_adv;
    assign cfg.ready = 1'b1;

    assign s1_valid_next  = s1_adv ? acc : s1_valid_reg;
    assign out_valid_next = s2_adv ? s1_valid_reg : out_valid_reg;

    // Pick the current chunk, starting over on restart or when outside the image
    always_comb
    begin
        w   = clamp_dim(width_reg);
        h   = clamp_dim(height_reg);
        clr = req.restart || (tile_row_reg >= h) || (tile_step_reg >= w);

        cur_row   = clr ? '0 : tile_row_reg;
        cur_step  = clr ? '0 : tile_step_reg;
        cur_sub   = clr ? '0 : sub_reg;
        cur_t     = clr ? '0 : t_reg;
        cur_mw    = clr ? '0 : mw_reg;
        cur_mh    = clr ? '0 : mh_reg;
        cur_base  = clr ? '0 : row_base_reg;
        cur_count = clr ? '0 : count_reg;

        odd   = cur_row[0];
        col   = odd ? (w - CW'(1) - cur_step) : cur_step;
        place = place_lookup(odd, cur_sub);

        lin = cur_base + SRC_W'(col * TWB)
            + (place[0] ? SRC_W'(SUBTILE_ROW_BYTES) : '0)
            + SRC_W'(cur_mw * MICRO_ROW_BYTES);
        rowoff = (place[1] ? RW'(SUBTILE_ROWS) : '0)
               + RW'(cur_mh * MICRO_ROWS) + RW'(cur_t);

        sub_end  = (cur_t == TW'(T_LAST)) && (cur_mw == MWW'(MW_LAST))
                && (cur_mh == MHW'(MH_LAST));
        cur_last = (cur_row == h - CW'(1)) && (cur_step == w - CW'(1))
                && (cur_sub == SUB_LAST) && sub_end;
    end

    // Advance the position: micro row, micro column, micro row group, sub-tile, tile, tile row
    always_comb
    begin
        tile_row_next  = cur_row;
        tile_step_next = cur_step;
        sub_next       = cur_sub;
        t_next         = cur_t;
        mw_next        = cur_mw;
        mh_next        = cur_mh;
        row_base_next  = cur_base;
        count_next     = cur_count + COUNT_W'(1);
        if (cur_last)
        begin
            tile_row_next  = '0;
            tile_step_next = '0;
            sub_next       = '0;
            t_next         = '0;
            mw_next        = '0;
            mh_next        = '0;
            row_base_next  = '0;
            count_next     = '0;
        end
        else if (!sub_end)
        begin
            if (cur_t != TW'(MICRO_ROWS - 1))
                t_next = cur_t + TW'(1);
            else
            begin
                t_next = '0;
                if (cur_mw != MWW'(MPR - 1))
                    mw_next = cur_mw + MWW'(1);
                else
                begin
                    mw_next = '0;
                    mh_next = cur_mh + MHW'(1);
                end
            end
        end
        else
        begin
            // Sub-tile done: move to the next sub-tile, tile or tile row
            t_next  = '0;
            mw_next = '0;
            mh_next = '0;
            if (cur_sub != SUB_LAST)
                sub_next = cur_sub + subtile_t'(1);
            else
            begin
                sub_next = '0;
                if (cur_step != w - CW'(1))
                    tile_step_next = cur_step + CW'(1);
                else
                begin
                    tile_step_next = '0;
                    tile_row_next  = cur_row + CW'(1);
                    row_base_next  = cur_base + SRC_W'(stride_reg * TR);
                end
            end
        end
    end

    // Hold control state, configuration and position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= DIM_W'(1);
            height_reg    <= DIM_W'(1);
            stride_reg    <= STRIDE_W'(128);
            tile_row_reg  <= '0;
            tile_step_reg <= '0;
            sub_reg       <= '0;
            t_reg         <= '0;
            mw_reg        <= '0;
            mh_reg        <= '0;
            row_base_reg  <= '0;
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                case (cfg_reg_t'(cfg.addr))
                    REG_WIDTH:  width_reg  <= cfg.data[DIM_W-1:0];
                    REG_HEIGHT: height_reg <= cfg.data[DIM_W-1:0];
                    REG_STRIDE: stride_reg <= cfg.data[STRIDE_W-1:0];
                    default: ;
                endcase
            end
            if (acc)
            begin
                tile_row_reg  <= tile_row_next;
                tile_step_reg <= tile_step_next;
                sub_reg       <= sub_next;
                t_reg         <= t_next;
                mw_reg        <= mw_next;
                mh_reg        <= mh_next;
                row_base_reg  <= row_base_next;
                count_reg     <= count_next;
            end
        end
    end

    // Load the pipeline payload when each stage advances
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_lin_reg    <= lin;
            s1_rowoff_reg <= rowoff;
            s1_count_reg  <= cur_count;
            s1_last_reg   <= cur_last;
        end
        if (s2_adv)
        begin
            out_src_reg  <= s1_lin_reg + SRC_W'(SRC_W'(s1_rowoff_reg) * SRC_W'(stride_reg));
            out_off_reg  <= OUT_W'(s1_count_reg * MICRO_ROW_BYTES);
            out_last_reg <= s1_last_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.src_offset = out_src_reg;
    assign rsp.out_offset = out_off_reg;
    assign rsp.last_chunk = out_last_reg;

    // Wrap to the first chunk after the last one
    a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        acc && cur_last |=> tile_row_reg == '0 && tile_step_reg == '0 && count_reg == '0
                            && row_base_reg == '0)
        else $error("position not cleared after last chunk");

    // Destination count steps by one for every chunk that is not the last
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        acc && !cur_last |=> count_reg == $past(cur_count + COUNT_W'(1)))
        else $error("destination count did not advance by one");

    // A stalled first stage keeps its item
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_adv |=> s1_valid_reg && $stable(s1_lin_reg)
                                    && $stable(s1_count_reg))
        else $error("first stage lost its item while stalled");

    // Micro-tile counters stay inside a sub-tile
    a_micro_range: assert property (@(posedge clk) disable iff (!rst_n)
        mw_reg <= MWW'(MPR - 1) && mh_reg <= MHW'(MH_LAST))
        else $error("micro-tile counter out of range");

endmodule

### bench/chunk_check_pkg.sv
// Scoreboard for the linear-to-tiled address generator bench: tracks the tiling
// walk and the register settings, and checks each chunk address pair.
// Depends on ltag_pkg for field widths, register names and sub-tile placements.
package chunk_check_pkg;
    import ltag_pkg::*;

    // Tiling geometry at the block's default parameters
    localparam int CHUNK_BYTES        = 16;
    localparam int MICRO_H            = 4;
    localparam int SUB_H              = 16;
    localparam int SUB_ROW_BYTES      = 64;
    localparam int TILE_LIMIT         = 64;
    localparam int MICROS_ACROSS      = SUB_ROW_BYTES / CHUNK_BYTES;
    localparam int CHUNKS_PER_SUBTILE = (SUB_H / MICRO_H) * MICROS_ACROSS;
    localparam int TILE_H             = 2 * SUB_H;
    localparam int TILE_ROW_BYTES     = 2 * SUB_ROW_BYTES;
    localparam int REPORT_LIMIT       = 10;

    // Sub-tile visiting order: even tile rows, then odd tile rows
    localparam place_t EVEN_PLACES [4] = '{PLACE_TL, PLACE_BL, PLACE_BR, PLACE_TR};
    localparam place_t ODD_PLACES  [4] = '{PLACE_BR, PLACE_TR, PLACE_TL, PLACE_BL};

    typedef struct packed {
        logic [SRC_W-1:0] src_offset;
        logic [OUT_W-1:0] out_offset;
        logic             last_chunk;
    } chunk_addr_t;

    class chunk_scoreboard;
        // Register copies
        logic [DIM_W-1:0]    width_tiles;
        logic [DIM_W-1:0]    height_tiles;
        logic [STRIDE_W-1:0] stride_bytes;

        // Walk position: names the chunk that the next request gets
        logic [5:0]         tile_row;
        logic [5:0]         tile_step;
        subtile_t           slot;
        logic [5:0]         chunk_idx;
        logic [SRC_W-1:0]   row_base;
        logic [COUNT_W-1:0] out_count;

        chunk_addr_t expected_chunks[$];
        int          failures;
        int          checked;
        int          image_ends;

        function new();
            width_tiles  = 7'd1;
            height_tiles = 7'd1;
            stride_bytes = 16'd128;
            failures     = 0;
            checked      = 0;
            image_ends   = 0;
            rewind();
        endfunction

        function void rewind();
            tile_row  = '0;
            tile_step = '0;
            slot      = '0;
            chunk_idx = '0;
            row_base  = '0;
            out_count = '0;
        endfunction

        function int unsigned clamp_tiles(logic [DIM_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > TILE_LIMIT)
                return TILE_LIMIT;
            return v;
        endfunction

        function void write_config(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                REG_WIDTH:  width_tiles  = data[DIM_W-1:0];
                REG_HEIGHT: height_tiles = data[DIM_W-1:0];
                REG_STRIDE: stride_bytes = data[STRIDE_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_chunks.size();
        endfunction

        // Work out the address pair for one accepted request, then advance the walk
        function void note_request(logic restart);
            int unsigned     w, h, col, t, mw, mh;
            place_t          pl;
            logic            odd;
            logic            is_last;
            longint unsigned src;
            chunk_addr_t     exp_chunk;

            w = clamp_tiles(width_tiles);
            h = clamp_tiles(height_tiles);
            // Start over on restart or when the position fell outside the image
            if (restart || tile_row >= h || tile_step >= w || chunk_idx >= CHUNKS_PER_SUBTILE)
                rewind();

            odd = tile_row[0];
            col = odd ? (w - 1 - tile_step) : tile_step;
            pl  = odd ? ODD_PLACES[slot] : EVEN_PLACES[slot];

            t  = chunk_idx % MICRO_H;
            mw = (chunk_idx / MICRO_H) % MICROS_ACROSS;
            mh = chunk_idx / (MICRO_H * MICROS_ACROSS);

            src = longint'(row_base) + longint'(col) * TILE_ROW_BYTES;
            if (pl[0])
                src += SUB_ROW_BYTES;
            if (pl[1])
                src += longint'(stride_bytes) * SUB_H;
            src += longint'(mh * MICRO_H + t) * longint'(stride_bytes) + mw * CHUNK_BYTES;

            is_last = (tile_row == h - 1) && (tile_step == w - 1) && (slot == SUB_LAST) &&
                      (chunk_idx == CHUNKS_PER_SUBTILE - 1);

            exp_chunk.src_offset = SRC_W'(src);
            exp_chunk.out_offset = OUT_W'(longint'(out_count) * CHUNK_BYTES);
            exp_chunk.last_chunk = is_last;
            expected_chunks.push_back(exp_chunk);

            // Advance: chunk, sub-tile, tile, tile row; wrap after the last chunk
            if (is_last) begin
                rewind();
            end
            else begin
                out_count++;
                chunk_idx++;
                if (chunk_idx >= CHUNKS_PER_SUBTILE) begin
                    chunk_idx = '0;
                    if (slot == SUB_LAST) begin
                        slot = '0;
                        if (int'(tile_step) + 1 >= w) begin
                            tile_step = '0;
                            tile_row++;
                            row_base = SRC_W'(longint'(row_base) + longint'(stride_bytes) * TILE_H);
                        end
                        else begin
                            tile_step++;
                        end
                    end
                    else begin
                        slot++;
                    end
                end
            end
        endfunction

        // Compare one accepted response with the oldest expected address pair
        function void check_response(logic [SRC_W-1:0] src, logic [OUT_W-1:0] dst, logic fin);
            chunk_addr_t exp_chunk;

            if (expected_chunks.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("mismatch: response with nothing expected: src=%h out=%h last=%b",
                             src, dst, fin);
                return;
            end
            exp_chunk = expected_chunks.pop_front();
            checked++;
            if (fin)
                image_ends++;
            if (src !== exp_chunk.src_offset || dst !== exp_chunk.out_offset ||
                fin !== exp_chunk.last_chunk) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("mismatch on chunk %0d: expected src=%h out=%h last=%b, got src=%h out=%h last=%b",
                             checked, exp_chunk.src_offset, exp_chunk.out_offset,
                             exp_chunk.last_chunk, src, dst, fin);
            end
        endfunction
    endclass

endpackage

### bench/tb.sv
// Top-level bench for linear_to_tiled_address_generator: drives requests and
// register writes, stalls responses at random and checks every address pair.
// Depends on ltag_pkg, ltag_ifs and chunk_check_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ltag_pkg::*;
    import chunk_check_pkg::*;

    localparam int RESET_CYCLES    = 11;
    localparam int IDLE_LIMIT      = 2000;
    localparam int LONG_HOLD       = 400;
    localparam int TARGET_REQUESTS = 1950;
    localparam int DRAIN_CYCLES    = 8;
    localparam int PAD_W           = CFG_DATA_W - DIM_W;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    ltag_req_if req_ch();
    ltag_rsp_if rsp_ch();
    ltag_cfg_if cfg_ch();

    linear_to_tiled_address_generator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    chunk_scoreboard sb = new();

    // Idle knobs for the sender and the receiver
    int send_gap_pct;
    int take_stall_pct;
    bit hold_request;

    int requests_sent;
    int restarts_sent;
    int config_writes;
    int phases_run;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(9, 0) == 0)
            return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(3, 0))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    // Small images most of the time so that the walk wraps often
    function automatic logic [DIM_W-1:0] pick_dim();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 65)
            return DIM_W'($urandom_range(3, 1));
        if (roll < 75)
            return '0;
        if (roll < 85)
            return DIM_W'($urandom_range(127, 64));
        return DIM_W'($urandom);
    endfunction

    function automatic logic [STRIDE_W-1:0] pick_stride();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 40)
            return STRIDE_W'($urandom_range(2048, 128));
        if (roll < 60)
            return STRIDE_W'($urandom_range(127, 0));
        if (roll < 75)
            return '1;
        return STRIDE_W'($urandom);
    endfunction

    // One register write transfer; valid stays up for a following write
    task automatic put_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= addr;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.write_config(addr, data);
        config_writes++;
    endtask

    // Write the selected registers, with junk in the unused upper bits
    task automatic program_regs(input logic [3:0] sel, input logic [DIM_W-1:0] w,
                                input logic [DIM_W-1:0] h, input logic [STRIDE_W-1:0] stride);
        if (sel[0])
            put_reg(REG_WIDTH, {PAD_W'($urandom), w});
        if (sel[1])
            put_reg(REG_HEIGHT, {PAD_W'($urandom), h});
        if (sel[2])
            put_reg(REG_STRIDE, stride);
        if (sel[3])
            put_reg(REG_SPARE, CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // Offer one request after an optional gap and hold it until the transfer
    task automatic send_chunk_request(input logic restart);
        int gap;
        gap = 0;
        if (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct)
            gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid   <= 1'b0;
            req_ch.restart <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.restart <= restart;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(restart);
        requests_sent++;
        if (restart)
            restarts_sent++;
    endtask

    // Drop valid and wait for every expected response
    task automatic finish_burst();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Response side: check each transfer, then decide ready for the next cycle
    initial begin : response_sink
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.src_offset, rsp_ch.out_offset, rsp_ch.last_chunk);
            if (hold_request) begin
                stall_left   = LONG_HOLD;
                hold_request = 1'b0;
            end
            else if (stall_left == 0 && take_stall_pct != 0 &&
                     $urandom_range(99, 0) < take_stall_pct) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run after a long stretch with no transfer anywhere
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int burst_len;

        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.restart <= 1'b0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.addr    <= REG_WIDTH;
        cfg_ch.data    <= '0;
        send_gap_pct   = 0;
        take_stall_pct = 0;
        hold_request   = 1'b0;
        requests_sent  = 0;
        restarts_sent  = 0;
        config_writes  = 0;
        phases_run     = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: first chunks, then a restart in mid-image
        send_chunk_request(1'b1);
        repeat (3) send_chunk_request(1'b0);
        send_chunk_request(1'b1);
        send_chunk_request(1'b0);
        finish_burst();

        // Zero sizes count as one tile; zero stride is taken as given
        program_regs(4'b1111, 7'd0, 7'd0, 16'h0000);
        repeat (3) send_chunk_request(1'b0);
        finish_burst();

        // Sizes above the tile limit clamp; widest stride
        program_regs(4'b0111, 7'h7F, 7'h7F, 16'hFFFF);
        repeat (3) send_chunk_request(1'b0);
        send_chunk_request(1'b1);
        finish_burst();

        // Largest legal image with the default stride
        program_regs(4'b0111, 7'd64, 7'd64, 16'd128);
        repeat (4) send_chunk_request(1'b0);
        finish_burst();

        // Random phases: long runs of plain advances, now and then a restart
        while (requests_sent < TARGET_REQUESTS) begin
            phases_run++;
            send_gap_pct   = pick_pct();
            take_stall_pct = pick_pct();
            if (phases_run == 2) begin
                // Hold the response side while requests keep coming
                send_gap_pct = 0;
                hold_request = 1'b1;
            end
            if ($urandom_range(9, 0) < 6)
                program_regs(4'($urandom), pick_dim(), pick_dim(), pick_stride());
            burst_len = $urandom_range(150, 30);
            for (int i = 0; i < burst_len; i++)
                send_chunk_request((i == 0 && $urandom_range(1, 0) == 1) ||
                                   $urandom_range(39, 0) == 0);
            finish_burst();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d chunk requests (%0d restarts) in %0d random phases, %0d register writes",
                 requests_sent, restarts_sent, phases_run, config_writes);
        $display("summary: %0d address pairs checked, %0d image ends seen, %0d mismatches",
                 sb.checked, sb.image_ends, sb.failures);
        if (sb.failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
